/* hw/rtl/hkrb_pkg.sv */
// Shared types and constants for the keyboard report builder.
// No dependencies; imported by hid_keyboard_report_builder.
package hkrb_pkg;

    localparam int KEY_SLOT_COUNT = 6;
    localparam int SHOWN_SLOTS    = 6;
    localparam int LAYOUT_DEPTH   = 128;
    localparam int LAYOUT_AW      = $clog2(LAYOUT_DEPTH);
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // request kinds
    localparam logic [2:0] KIND_PRESS       = 3'd0;
    localparam logic [2:0] KIND_RELEASE     = 3'd1;
    localparam logic [2:0] KIND_TYPE        = 3'd2;
    localparam logic [2:0] KIND_RELEASE_ALL = 3'd3;
    localparam logic [2:0] KIND_LAYOUT      = 3'd4;

    // register index (paddr bit 2)
    localparam logic REG_ISO_REPLACE = 1'b0;
    localparam logic REG_ISO_EXTRA   = 1'b1;

    localparam logic [5:0] ISO_REPLACE_RESET = 6'd50;
    localparam logic [7:0] ISO_EXTRA_RESET   = 8'd100;

    localparam logic [7:0] MOD_KEY_FIRST  = 8'hE0;
    localparam logic [7:0] MOD_KEY_END    = 8'hE8;
    localparam logic [7:0] RAW_BASE       = 8'h88;
    localparam logic [7:0] MOD_CODE_BASE  = 8'h80;
    localparam logic [7:0] KEY_LIMIT      = 8'hA5;
    localparam logic [7:0] ALTGR_BIT      = 8'h40;
    localparam logic [7:0] SHIFT_BIT      = 8'h02;
    localparam logic [7:0] ALTGR_KEY_MASK = 8'h3F;
    localparam logic [7:0] SHIFT_KEY_MASK = 8'h7F;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] code;
        logic [7:0] entry_value;
    } key_req_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] slot_key_a;
        logic [7:0] slot_key_b;
        logic [7:0] slot_key_c;
        logic [7:0] slot_key_d;
        logic [7:0] slot_key_e;
        logic [7:0] slot_key_f;
        logic       from_release;
        logic       last_of_run;
    } key_report_t;

endpackage

/* hw/rtl/hid_keyboard_report_builder.sv */
// Keyboard report builder: six-slot report plus modifier byte, layout table in RAM.
// Depends on hkrb_pkg.
// A request is registered in the working stage, then its report goes to the output
// register. Throughput: one request per cycle while the output is not stalled; a type
// request does a press half, then a release half: one report per cycle at most.
// Reset: slots, modifier byte and layout valid bits clear at once, the
// registers take their reset values; no clearing pass is needed.
module hid_keyboard_report_builder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  hkrb_pkg::key_req_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output hkrb_pkg::key_report_t        out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hkrb_pkg::APB_AW-1:0]  paddr,
    input  logic [hkrb_pkg::APB_DW-1:0]  pwdata,
    output logic [hkrb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import hkrb_pkg::*;

    // configuration
    logic [5:0] iso_replace_reg;
    logic [7:0] iso_extra_reg;

    // layout memory and per-entry valid bits
    logic [7:0]           layout_mem [LAYOUT_DEPTH];
    logic [LAYOUT_DEPTH-1:0] entry_valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;

    // working stage
    logic                 s1_valid_reg;
    logic [2:0]           s1_kind_reg;
    logic [7:0]           s1_code_reg;
    logic                 phase_reg;

    // report state
    logic [7:0]           slots_reg [KEY_SLOT_COUNT];
    logic [7:0]           mod_reg;

    // output register
    logic                 out_valid_reg;
    key_report_t          out_reg;

    logic                 accept;
    logic [LAYOUT_AW-1:0] rd_addr;
    logic                 key_kind;
    logic                 clear_kind;
    logic                 pressing;
    logic                 last_half;
    logic                 out_free;
    logic                 do_half;
    logic                 s1_done;
    logic [7:0]           entry;
    logic [7:0]           slots_next [KEY_SLOT_COUNT];
    logic [7:0]           mod_next;
    logic                 hit;
    logic [7:0]           shown [SHOWN_SLOTS];

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_replace_reg <= ISO_REPLACE_RESET;
            iso_extra_reg   <= ISO_EXTRA_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_ISO_REPLACE: iso_replace_reg <= pwdata[5:0];
                REG_ISO_EXTRA:   iso_extra_reg   <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ISO_REPLACE: prdata = {{(APB_DW-6){1'b0}}, iso_replace_reg};
            REG_ISO_EXTRA:   prdata = {{(APB_DW-8){1'b0}}, iso_extra_reg};
            default:         prdata = '0;
        endcase
    end

    assign key_kind   = (s1_kind_reg == KIND_PRESS) || (s1_kind_reg == KIND_RELEASE)
                        || (s1_kind_reg == KIND_TYPE);
    assign clear_kind = (s1_kind_reg == KIND_RELEASE_ALL);
    assign pressing   = (s1_kind_reg == KIND_PRESS)
                        || ((s1_kind_reg == KIND_TYPE) && !phase_reg);
    assign last_half  = (s1_kind_reg != KIND_TYPE) || phase_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign do_half    = s1_valid_reg && (key_kind || clear_kind) && out_free;
    assign s1_done    = s1_valid_reg
                        && (!(key_kind || clear_kind) || (out_free && last_half));
    assign in_stall   = s1_valid_reg && !s1_done;
    assign accept     = in_valid && !in_stall;
    assign rd_addr    = in_data.code[LAYOUT_AW-1:0];
    assign entry      = rd_valid_reg ? rd_data_reg : 8'h00;

    // layout table: written by an accepted layout request, read registered at every accept
    always_ff @(posedge clk)
    begin
        if (accept && (in_data.kind == KIND_LAYOUT) && !in_data.code[7])
        begin
            layout_mem[rd_addr] <= in_data.entry_value;
        end
        if (accept)
        begin
            rd_data_reg <= layout_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if ((in_data.kind == KIND_LAYOUT) && !in_data.code[7])
            begin
                entry_valid_reg[rd_addr] <= 1'b1;
            end
            rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    // one press or release half, or a release-all clear, against the current report
    always_comb
    begin
        logic [7:0] key;
        logic [7:0] mbit;
        logic       have_key;
        logic       found;
        logic       placed;

        mod_next   = mod_reg;
        slots_next = slots_reg;
        hit        = 1'b0;
        key        = 8'h00;
        mbit       = 8'h00;
        have_key   = 1'b0;
        found      = 1'b0;
        placed     = 1'b0;

        if (clear_kind)
        begin
            mod_next = 8'h00;
            for (int i = 0; i < KEY_SLOT_COUNT; i++)
            begin
                slots_next[i] = 8'h00;
            end
            hit = 1'b1;
        end
        else
        begin
            if ((s1_code_reg >= MOD_KEY_FIRST) && (s1_code_reg < MOD_KEY_END))
            begin
                key      = s1_code_reg;
                have_key = 1'b1;
            end
            else if (s1_code_reg >= RAW_BASE)
            begin
                key      = s1_code_reg - RAW_BASE;
                have_key = 1'b1;
            end
            else if (s1_code_reg >= MOD_CODE_BASE)
            begin
                mbit     = 8'b1 << s1_code_reg[2:0];
                mod_next = pressing ? (mod_next | mbit) : (mod_next & ~mbit);
            end
            else if (entry != 8'h00)
            begin
                if ((entry & 8'hC0) == 8'hC0)
                begin
                    mbit = ALTGR_BIT;
                    key  = entry & ALTGR_KEY_MASK;
                end
                else if (entry[7])
                begin
                    mbit = SHIFT_BIT;
                    key  = entry & SHIFT_KEY_MASK;
                end
                else
                begin
                    key = entry;
                end
                mod_next = pressing ? (mod_next | mbit) : (mod_next & ~mbit);
                if (key == {2'b00, iso_replace_reg})
                begin
                    key = iso_extra_reg;
                end
                have_key = 1'b1;
            end

            if (have_key)
            begin
                if ((key >= MOD_KEY_FIRST) && (key < MOD_KEY_END))
                begin
                    mbit     = 8'b1 << key[2:0];
                    mod_next = pressing ? (mod_next | mbit) : (mod_next & ~mbit);
                    hit      = 1'b1;
                end
                else if ((key != 8'h00) && (key < KEY_LIMIT))
                begin
                    if (pressing)
                    begin
                        for (int i = 0; i < KEY_SLOT_COUNT; i++)
                        begin
                            if (slots_reg[i] == key)
                            begin
                                found = 1'b1;
                            end
                        end
                        // take the first empty slot
                        for (int i = 0; i < KEY_SLOT_COUNT; i++)
                        begin
                            if (!found && !placed && (slots_reg[i] == 8'h00))
                            begin
                                slots_next[i] = key;
                                placed        = 1'b1;
                            end
                        end
                        hit = found || placed;
                    end
                    else
                    begin
                        for (int i = 0; i < KEY_SLOT_COUNT; i++)
                        begin
                            if (slots_reg[i] == key)
                            begin
                                slots_next[i] = 8'h00;
                            end
                        end
                        hit = 1'b1;
                    end
                end
            end
        end
    end

    for (genvar gi = 0; gi < SHOWN_SLOTS; gi++)
    begin : g_shown
        if (gi < KEY_SLOT_COUNT)
        begin : g_slot
            assign shown[gi] = slots_next[gi];
        end
        else
        begin : g_none
            assign shown[gi] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            mod_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++)
            begin
                slots_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (do_half)
            begin
                mod_reg   <= mod_next;
                slots_reg <= slots_next;
                phase_reg <= !last_half;
            end

            if (do_half && hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= in_data.kind;
            s1_code_reg <= in_data.code;
        end
        if (do_half && hit)
        begin
            out_reg.modifier_bits <= mod_next;
            out_reg.slot_key_a    <= shown[0];
            out_reg.slot_key_b    <= shown[1];
            out_reg.slot_key_c    <= shown[2];
            out_reg.slot_key_d    <= shown[3];
            out_reg.slot_key_e    <= shown[4];
            out_reg.slot_key_f    <= shown[5];
            out_reg.from_release  <= !pressing;
            out_reg.last_of_run   <= last_half;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/tb_hid_keyboard_report_builder.sv */
`timescale 1ns / 100ps
// Self-checking bench for hid_keyboard_report_builder: random and directed key requests,
// APB register writes, and a built-in report predictor. Depends on hkrb_pkg and the RTL.
module tb_hid_keyboard_report_builder;
    import hkrb_pkg::*;

    localparam int PHASE_ITEMS = 517;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    key_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    key_report_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // predictor state
    logic [7:0] layout_mem [LAYOUT_DEPTH];
    logic [7:0] held_keys [KEY_SLOT_COUNT];
    logic [7:0] mod_byte;
    logic [5:0] iso_replace;
    logic [7:0] iso_extra;

    key_req_t key_requests[$];
    key_report_t expected_reports[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 36;
    int recv_stall_pct = 51;

    hid_keyboard_report_builder i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("hid_keyboard_report_builder: mismatch");
            $finish;
        end
    end

    function automatic bit is_mod_key(logic [7:0] k);
        return k >= MOD_KEY_FIRST && k < MOD_KEY_END;
    endfunction

    function automatic bit update_slots(logic [7:0] k, bit pressing);
        if (is_mod_key(k))
        begin
            if (pressing)
                mod_byte |= 8'(1 << k[2:0]);
            else
                mod_byte &= ~8'(1 << k[2:0]);
            return 1'b1;
        end
        if (k == 8'h00 || k >= KEY_LIMIT)
            return 1'b0;
        if (!pressing)
        begin
            for (int i = 0; i < KEY_SLOT_COUNT; i++)
                if (held_keys[i] == k)
                    held_keys[i] = 8'h00;
            return 1'b1;
        end
        for (int i = 0; i < KEY_SLOT_COUNT; i++)
            if (held_keys[i] == k)
                return 1'b1;
        for (int i = 0; i < KEY_SLOT_COUNT; i++)
            if (held_keys[i] == 8'h00)
            begin
                held_keys[i] = k;
                return 1'b1;
            end
        return 1'b0;
    endfunction

    // Map a code to a modifier effect and keycode; slots update only when a keycode results.
    function automatic bit resolve_code(logic [7:0] code, bit pressing);
        logic [7:0] k;
        logic [7:0] entry;
        logic [7:0] mod_mask;
        mod_mask = 8'h00;
        if (is_mod_key(code))
            k = code;
        else if (code >= RAW_BASE)
            k = code - RAW_BASE;
        else if (code >= MOD_CODE_BASE)
        begin
            if (pressing)
                mod_byte |= 8'(1 << code[2:0]);
            else
                mod_byte &= ~8'(1 << code[2:0]);
            return 1'b0;
        end
        else
        begin
            entry = layout_mem[code[6:0]];
            if (entry == 8'h00)
                return 1'b0;
            k = entry;
            if (entry[7:6] == 2'b11)
            begin
                mod_mask = ALTGR_BIT;
                k = entry & ALTGR_KEY_MASK;
            end
            else if (entry[7])
            begin
                mod_mask = SHIFT_BIT;
                k = entry & SHIFT_KEY_MASK;
            end
            if (pressing)
                mod_byte |= mod_mask;
            else
                mod_byte &= ~mod_mask;
            if (k == {2'b00, iso_replace})
                k = iso_extra;
        end
        return update_slots(k, pressing);
    endfunction

    function automatic key_report_t snapshot(bit from_rel);
        key_report_t rep;
        rep.modifier_bits = mod_byte;
        rep.slot_key_a = held_keys[0];
        rep.slot_key_b = held_keys[1];
        rep.slot_key_c = held_keys[2];
        rep.slot_key_d = held_keys[3];
        rep.slot_key_e = held_keys[4];
        rep.slot_key_f = held_keys[5];
        rep.from_release = from_rel;
        rep.last_of_run = 1'b0;
        return rep;
    endfunction

    function automatic void predict_reports(key_req_t r);
        key_report_t run [2];
        int n;
        n = 0;
        case (r.kind)
            KIND_PRESS:
                if (resolve_code(r.code, 1'b1))
                begin
                    run[n] = snapshot(1'b0);
                    n = n + 1;
                end
            KIND_RELEASE:
                if (resolve_code(r.code, 1'b0))
                begin
                    run[n] = snapshot(1'b1);
                    n = n + 1;
                end
            KIND_TYPE:
            begin
                if (resolve_code(r.code, 1'b1))
                begin
                    run[n] = snapshot(1'b0);
                    n = n + 1;
                end
                if (resolve_code(r.code, 1'b0))
                begin
                    run[n] = snapshot(1'b1);
                    n = n + 1;
                end
            end
            KIND_RELEASE_ALL:
            begin
                for (int i = 0; i < KEY_SLOT_COUNT; i++)
                    held_keys[i] = 8'h00;
                mod_byte = 8'h00;
                run[n] = snapshot(1'b1);
                n = n + 1;
            end
            KIND_LAYOUT:
                if (!r.code[7])
                    layout_mem[r.code[6:0]] = r.entry_value;
            default:
                ;
        endcase
        if (n > 0)
            run[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_reports.push_back(run[i]);
    endfunction

    // Sender: hold the payload while stalled, pick the next request otherwise.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_reports(in_data);
            if (!in_valid || !in_stall)
            begin
                if (key_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= key_requests.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        key_report_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report with none pending: %h", out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("modifier_bits", want.modifier_bits, out_data.modifier_bits);
                    check_field("slot_key_a", want.slot_key_a, out_data.slot_key_a);
                    check_field("slot_key_b", want.slot_key_b, out_data.slot_key_b);
                    check_field("slot_key_c", want.slot_key_c, out_data.slot_key_c);
                    check_field("slot_key_d", want.slot_key_d, out_data.slot_key_d);
                    check_field("slot_key_e", want.slot_key_e, out_data.slot_key_e);
                    check_field("slot_key_f", want.slot_key_f, out_data.slot_key_f);
                    check_field("from_release", 8'(want.from_release),
                                8'(out_data.from_release));
                    check_field("last_of_run", 8'(want.last_of_run),
                                8'(out_data.last_of_run));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic key_req_t req(logic [2:0] kind, logic [7:0] code, logic [7:0] entry);
        key_req_t r;
        r.kind = kind;
        r.code = code;
        r.entry_value = entry;
        return r;
    endfunction

    function automatic logic [7:0] pick_key_code();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 8'($urandom_range(8'h20, 8'h3F));
        else if (p < 50)
            return 8'($urandom_range(8'h00, 8'h7F));
        else if (p < 60)
            return 8'($urandom_range(8'h80, 8'h87));
        else if (p < 72)
            return 8'($urandom_range(8'hE0, 8'hE7));
        else if (p < 92)
            return 8'($urandom_range(8'h89, 8'h92));
        return 8'($urandom_range(8'h88, 8'hFF));
    endfunction

    // Favor entries that hit the ISO replacement in each encoding.
    function automatic logic [7:0] pick_entry();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 8'h00;
        else if (p < 15)
            return {2'b00, iso_replace};
        else if (p < 20)
            return {2'b10, iso_replace};
        else if (p < 25)
            return {2'b11, iso_replace};
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic key_req_t random_request();
        int p;
        logic [2:0] kind;
        logic [7:0] code;
        logic [7:0] entry;
        p = $urandom_range(0, 99);
        code = pick_key_code();
        entry = 8'($urandom_range(0, 255));
        if (p < 6)
        begin
            kind = KIND_LAYOUT;
            code = (p < 4) ? 8'($urandom_range(8'h20, 8'h3F)) : 8'($urandom_range(0, 255));
            entry = pick_entry();
        end
        else if (p < 36)
            kind = KIND_PRESS;
        else if (p < 62)
            kind = KIND_RELEASE;
        else if (p < 85)
            kind = KIND_TYPE;
        else if (p < 90)
            kind = KIND_RELEASE_ALL;
        else if (p < 93)
            kind = 3'($urandom_range(5, 7));
        else
        begin
            kind = 3'($urandom_range(KIND_PRESS, KIND_TYPE));
            code = 8'($urandom_range(0, 255));
        end
        return req(kind, code, entry);
    endfunction

    task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ISO_REPLACE)
            iso_replace = value[5:0];
        else
            iso_extra = value[7:0];
    endtask

    // Hold off until every request is taken and every report is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (key_requests.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        key_req_t r;
        int useful;
        logic [APB_DW-1:0] rep_val;
        logic [APB_DW-1:0] extra_val;

        for (int i = 0; i < LAYOUT_DEPTH; i++)
            layout_mem[i] = 8'h00;
        for (int i = 0; i < KEY_SLOT_COUNT; i++)
            held_keys[i] = 8'h00;
        mod_byte = 8'h00;
        iso_replace = ISO_REPLACE_RESET;
        iso_extra = ISO_EXTRA_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // plain, shift, AltGr, ISO-replaced and zero-key layout entries, an ignored high-code write, then key requests
        key_requests.push_back(req(KIND_LAYOUT, 8'h41, 8'h04));
        key_requests.push_back(req(KIND_LAYOUT, 8'h42, 8'h85));
        key_requests.push_back(req(KIND_LAYOUT, 8'h43, 8'hC6));
        key_requests.push_back(req(KIND_LAYOUT, 8'h44, 8'd50));
        key_requests.push_back(req(KIND_LAYOUT, 8'h45, 8'h80));
        key_requests.push_back(req(KIND_LAYOUT, 8'hFF, 8'h07));
        key_requests.push_back(req(KIND_PRESS, 8'h00, 8'h00));
        key_requests.push_back(req(KIND_TYPE, 8'h42, 8'hFF));
        key_requests.push_back(req(KIND_TYPE, 8'h43, 8'h00));
        key_requests.push_back(req(KIND_TYPE, 8'h44, 8'h00));
        key_requests.push_back(req(KIND_PRESS, 8'h45, 8'h00));
        key_requests.push_back(req(KIND_PRESS, 8'h87, 8'h00));
        key_requests.push_back(req(KIND_RELEASE, 8'h80, 8'h00));
        key_requests.push_back(req(KIND_PRESS, 8'hE7, 8'h00));
        key_requests.push_back(req(KIND_RELEASE, 8'hE0, 8'h00));
        key_requests.push_back(req(KIND_PRESS, 8'h88, 8'h00));
        // fill every slot, then overflow and repeat a held key
        for (int i = 0; i < KEY_SLOT_COUNT + 1; i++)
            key_requests.push_back(req(KIND_PRESS, 8'(8'h89 + i), 8'h00));
        key_requests.push_back(req(KIND_PRESS, 8'h89, 8'h00));
        key_requests.push_back(req(KIND_RELEASE, 8'hFF, 8'h00));
        key_requests.push_back(req(3'd5, 8'hFF, 8'hFF));
        key_requests.push_back(req(3'd7, 8'h00, 8'h00));
        key_requests.push_back(req(KIND_RELEASE_ALL, 8'h00, 8'h00));
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 51;
                    rep_val = 63;
                    extra_val = 32'hE5;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_stall_pct = 36;
                    rep_val = 0;
                    extra_val = 32'hFF;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    rep_val = $urandom_range(1, 62);
                    extra_val = $urandom_range(0, 1) ? 32'hA5 : 32'h00;
                end
            endcase
            write_register(REG_ISO_REPLACE, rep_val);
            write_register(REG_ISO_EXTRA, extra_val);

            useful = 0;
            for (int c = 8'h20; c <= 8'h3F; c++)
            begin
                key_requests.push_back(req(KIND_LAYOUT, 8'(c), pick_entry()));
                useful++;
            end
            while (useful < PHASE_ITEMS)
            begin
                r = random_request();
                key_requests.push_back(r);
                if (!(r.kind > KIND_LAYOUT || (r.kind == KIND_LAYOUT && r.code[7])))
                    useful++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("hid_keyboard_report_builder: match");
        else
            $display("hid_keyboard_report_builder: mismatch");
        $finish;
    end

endmodule
